FILE: src/mm2_pkg.sv
// ----------------------------------------------------------------------------
// mm2_pkg
// shared constants, state and command types for the murmur2 hash block
// ----------------------------------------------------------------------------
package mm2_pkg;

  localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
  localparam int unsigned KEY_SHIFT   = 24;
  localparam int unsigned FIN_SHIFT_A = 13;
  localparam int unsigned FIN_SHIFT_B = 15;

  // datapath operations, at most one multiply each
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,   // item transfer: load key (premultiplied or masked tail), open hash
    OP_KMIX,   // k = (k ^ k >> 24) * m
    OP_HMIX,   // h = h * m ^ k
    OP_TAIL,   // h = (h ^ tail) * m
    OP_FIN,    // h = (h ^ h >> 13) * m
    OP_OUT     // result = h ^ h >> 15
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KMIX,
    ST_HMIX,
    ST_TAIL,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    op_t  op;
    logic full_word;
  } cmd_t;

endpackage

FILE: src/mm2_datapath.sv
// ----------------------------------------------------------------------------
// mm2_datapath
// hash and key registers around one shared constant multiplier
// ----------------------------------------------------------------------------
module mm2_datapath (
  input  logic          clk,
  input  logic          rst,
  input  mm2_pkg::cmd_t cmd,
  input  logic          cfg_write,
  input  logic [31:0]   seed_value,
  input  logic [31:0]   data_word,
  input  logic [2:0]    valid_bytes,
  input  logic          first_item,
  input  logic [31:0]   message_length,
  output logic [31:0]   hash_value
);
  import mm2_pkg::*;

  logic [31:0] seed;
  logic [31:0] h;
  logic [31:0] k;
  logic [31:0] tail_mask;
  logic [31:0] mul_a;
  logic [31:0] prod;

  always_comb begin
    case (valid_bytes)
      3'd1:    tail_mask = 32'h0000_00ff;
      3'd2:    tail_mask = 32'h0000_ffff;
      3'd3:    tail_mask = 32'h00ff_ffff;
      default: tail_mask = 32'hffff_ffff;
    endcase
  end

  always_comb begin
    case (cmd.op)
      OP_LOAD: mul_a = data_word;
      OP_KMIX: mul_a = k ^ (k >> KEY_SHIFT);
      OP_HMIX: mul_a = h;
      OP_TAIL: mul_a = h ^ k;
      OP_FIN:  mul_a = h ^ (h >> FIN_SHIFT_A);
      default: mul_a = h;
    endcase
  end

  assign prod = mul_a * MIX_MUL;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (cfg_write) begin
      seed <= seed_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h <= '0;
    end else begin
      case (cmd.op)
        OP_LOAD: if (first_item) h <= seed ^ message_length;
        OP_HMIX: h <= prod ^ k;
        OP_TAIL: h <= prod;
        OP_FIN:  h <= prod;
        default: ;
      endcase
    end
  end

  // key register: premultiplied word on a full word, masked tail otherwise
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: k <= cmd.full_word ? prod : (data_word & tail_mask);
      OP_KMIX: k <= prod;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) hash_value <= h ^ (h >> FIN_SHIFT_B);
  end

endmodule

FILE: src/mm2_ctrl.sv
// ----------------------------------------------------------------------------
// mm2_ctrl
// sequencer for word mixing, tail, final mix and result handshake
// ----------------------------------------------------------------------------
module mm2_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    valid_bytes,
  input  logic          first_item,
  input  logic          last_item,
  output logic          out_valid,
  input  logic          out_ready,
  output mm2_pkg::cmd_t cmd
);
  import mm2_pkg::*;

  state_t state;
  state_t state_next;
  logic   in_message;
  logic   last_q;
  logic   in_xfer;
  logic   active;
  logic   full_word;
  logic   out_free;

  assign in_ready  = (state == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign active    = first_item || in_message;
  assign full_word = !last_item || valid_bytes[2];
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer && active) begin
          if (full_word)               state_next = ST_KMIX;
          else if (valid_bytes != '0)  state_next = ST_TAIL;
          else                         state_next = ST_FIN;
        end
      end
      ST_KMIX: state_next = ST_HMIX;
      ST_HMIX: state_next = last_q ? ST_FIN : ST_IDLE;
      ST_TAIL: state_next = ST_FIN;
      ST_FIN:  state_next = ST_OUT;
      ST_OUT:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op        = OP_NONE;
    cmd.full_word = full_word;
    unique case (state)
      ST_IDLE: if (in_xfer) cmd.op = OP_LOAD;
      ST_KMIX: cmd.op = OP_KMIX;
      ST_HMIX: cmd.op = OP_HMIX;
      ST_TAIL: cmd.op = OP_TAIL;
      ST_FIN:  cmd.op = OP_FIN;
      ST_OUT:  if (out_free) cmd.op = OP_OUT;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      in_message <= 1'b0;
      last_q     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (in_xfer && active) begin
        in_message <= !last_item;
        last_q     <= last_item;
      end
      if (state == ST_OUT && out_free) out_valid <= 1'b1;
      else if (out_ready)              out_valid <= 1'b0;
    end
  end

  a_fin_to_out: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN |=> state == ST_OUT)
    else $error("final mix not followed by result stage");

  a_ignored_item: assert property (@(posedge clk) disable iff (rst)
    in_xfer && !first_item && !in_message |=> state == ST_IDLE)
    else $error("item outside a message started work");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    in_xfer && first_item && last_item && valid_bytes == 3'd0 |=> state == ST_FIN)
    else $error("empty single-item message skipped straight past final mix");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT && out_valid && !out_ready |=> state == ST_OUT)
    else $error("result stage overwrote a pending result");

endmodule

FILE: src/murmur2_hash32.sv
// ----------------------------------------------------------------------------
// murmur2_hash32
// streaming 32-bit murmurhash2 over little-endian message words
// ----------------------------------------------------------------------------
// One 32x32 constant multiplier (low 32 bits, m = 0x5bd1e995) is shared by
// the mixing steps. A full word goes through the transfer with k*m, the key
// xorshift and multiply, and the hash multiply and xor before the next ready.
// On the last item a tail step for a 1-3 byte tail, the final mix and the
// result load follow; a full last word skips the tail step and an empty last
// item goes straight to the final mix. An item outside an open message is
// taken and dropped. The result sits in an output register, so the next
// message streams in while it waits; only the result load of a later message
// stalls behind it. seed_value may be written at any idle time through
// cfg_valid.
// ----------------------------------------------------------------------------
module murmur2_hash32 (
  input  logic        clk,
  input  logic        rst,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] seed_value,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] data_word,
  input  logic [2:0]  valid_bytes,
  input  logic        first_item,
  input  logic        last_item,
  input  logic [31:0] message_length,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] hash_value
);
  import mm2_pkg::*;

  cmd_t cmd;

  // seed register takes a transfer in any cycle
  assign cfg_ready = 1'b1;

  mm2_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .valid_bytes (valid_bytes),
    .first_item  (first_item),
    .last_item   (last_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cmd         (cmd)
  );

  mm2_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg_write      (cfg_valid && cfg_ready),
    .seed_value     (seed_value),
    .data_word      (data_word),
    .valid_bytes    (valid_bytes),
    .first_item     (first_item),
    .message_length (message_length),
    .hash_value     (hash_value)
  );

endmodule

FILE: tb/tb_murmur2_hash32.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_murmur2_hash32
// self-checking bench for the streaming murmurhash2 block: directed corner
// messages, then random well-formed, broken and stray items under several
// seeds, with bursty input traffic and a patterned output stall
// ----------------------------------------------------------------------------
module tb_murmur2_hash32;
  import mm2_pkg::MIX_MUL;
  import mm2_pkg::KEY_SHIFT;
  import mm2_pkg::FIN_SHIFT_A;
  import mm2_pkg::FIN_SHIFT_B;

  localparam int IDLE_LIMIT   = 1000;  // cycles with no transfer at all
  localparam int PHASE_ITEMS  = 140;   // counted items per seed setting
  localparam int SETTLE_WAIT  = 8;     // quiet cycles before a seed write
  localparam int DRAIN_WAIT   = 20;    // quiet cycles at the very end
  localparam int MAX_STALL    = 24;    // longest receiver stall

  // one input transfer as the bench sees it
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  count;
    logic        is_first;
    logic        is_last;
    logic [31:0] length;
  } msg_item_t;

  // receiver stall patterns
  typedef enum int {
    RX_ALWAYS,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_t;

  // --------------------------------------------------------------------------
  // running-hash predictor and queue of hashes still to come out
  // --------------------------------------------------------------------------
  class hash_checker;
    logic [31:0] seed;
    logic [31:0] hash_state;
    bit          msg_open;
    logic [31:0] expected_hashes[$];
    int          errors;

    function new();
      seed       = '0;
      hash_state = '0;
      msg_open   = 0;
      errors     = 0;
    endfunction

    function logic [31:0] mix_word(logic [31:0] h, logic [31:0] k);
      k = k * MIX_MUL;
      k = k ^ (k >> KEY_SHIFT);
      k = k * MIX_MUL;
      return (h * MIX_MUL) ^ k;
    endfunction

    function logic [31:0] final_mix(logic [31:0] h);
      h = h ^ (h >> FIN_SHIFT_A);
      h = h * MIX_MUL;
      h = h ^ (h >> FIN_SHIFT_B);
      return h;
    endfunction

    // returns 1 when the item takes part in a message, 0 when it is dropped
    function bit predict_item(msg_item_t it);
      logic [31:0] h;
      logic [31:0] mask;
      if (it.is_first) begin
        hash_state = seed ^ it.length;
        msg_open   = 1;
      end
      if (!msg_open) return 0;
      h = hash_state;
      if (!it.is_last || it.count >= 3'd4) begin
        h = mix_word(h, it.word);
      end else if (it.count != 3'd0) begin
        mask = (32'h1 << (8 * it.count)) - 32'h1;
        h    = (h ^ (it.word & mask)) * MIX_MUL;
      end
      if (it.is_last) begin
        h = final_mix(h);
        msg_open = 0;
        expected_hashes.push_back(h);
      end
      hash_state = h;
      return 1;
    endfunction

    function void check_hash(logic [31:0] actual);
      logic [31:0] want;
      if (expected_hashes.size() == 0) begin
        $display("%0t: unexpected hash, expected none actual %h", $time, actual);
        errors++;
      end else begin
        want = expected_hashes.pop_front();
        if (actual !== want) begin
          $display("%0t: hash mismatch, expected %h actual %h", $time, want, actual);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] seed_value;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] data_word;
  logic [2:0]  valid_bytes;
  logic        first_item;
  logic        last_item;
  logic [31:0] message_length;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] hash_value;

  hash_checker sb;
  int          items_counted;
  int          burst_left;
  int          idle_cycles = 0;
  rx_mode_t    rx_mode = RX_ALWAYS;
  int          rx_mode_left = 0;
  int          rx_tick = 0;
  int          rx_stall_run = 0;
  bit          rx_next;

  murmur2_hash32 i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .seed_value     (seed_value),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_word      (data_word),
    .valid_bytes    (valid_bytes),
    .first_item     (first_item),
    .last_item      (last_item),
    .message_length (message_length),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hash_value     (hash_value)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // receiver: the stall pattern changes after a randomly drawn number of cycles
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_t'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(16, 96);
    end
    rx_mode_left--;
    rx_tick++;
    case (rx_mode)
      RX_ALWAYS: rx_next = 1'b1;
      RX_COIN:   rx_next = 1'($urandom_range(0, 1));
      RX_SPARSE: rx_next = ($urandom_range(0, 7) == 0);
      default:   rx_next = (rx_tick % 6 == 5);
    endcase
    // never stall longer than the watchdog allows for
    if (rx_stall_run >= MAX_STALL) rx_next = 1'b1;
    rx_stall_run = rx_next ? 0 : rx_stall_run + 1;
    out_ready <= rx_next;
  end

  // result monitor: every output transfer is checked against the oldest hash
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_hash(hash_value);
  end

  // watchdog: run is stuck when no channel transfers for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------

  // one input transfer; bursts of random length separated by random gaps
  task automatic send_item(msg_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    data_word      <= it.word;
    valid_bytes    <= it.count;
    first_item     <= it.is_first;
    last_item      <= it.is_last;
    message_length <= it.length;
    do @(posedge clk); while (!in_ready);
    if (sb.predict_item(it)) items_counted++;
  endtask

  // seed write, only once the block has gone quiet
  task automatic write_seed(logic [31:0] value);
    in_valid  <= 1'b0;
    burst_left = 0;
    while (sb.expected_hashes.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
    cfg_valid  <= 1'b1;
    seed_value <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.seed = value;
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic msg_item_t make_item(logic [31:0] word, logic [2:0] count,
                                          logic is_first, logic is_last,
                                          logic [31:0] length);
    msg_item_t it;
    it.word     = word;
    it.count    = count;
    it.is_first = is_first;
    it.is_last  = is_last;
    it.length   = length;
    return it;
  endfunction

  // random message; when cut short it stops without a last item
  task automatic send_message(bit complete);
    int          n_words;
    int          n_items;
    int          last_count;
    int          total_bytes;
    int          i;
    logic [2:0]  count;
    logic [31:0] len;
    // mostly short messages, now and then a long one
    n_words = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
    // last item: usually a 0-3 byte tail, sometimes a whole word
    if ($urandom_range(0, 4) == 0) last_count = $urandom_range(4, 7);
    else last_count = $urandom_range(0, 3);
    total_bytes = 4 * n_words + ((last_count >= 4) ? 4 : last_count);
    case ($urandom_range(0, 7))
      0:       len = $urandom;
      1:       len = 32'hffff_ffff;
      2:       len = 32'h0;
      default: len = total_bytes;
    endcase
    n_items = complete ? n_words + 1 : $urandom_range(1, n_words + 1);
    for (i = 0; i < n_items; i++) begin
      if (complete && i == n_words) begin
        send_item(make_item(pick_word(), last_count[2:0], i == 0, 1'b1, len));
      end else begin
        // short counts on inner words are ignored by the hash
        count = ($urandom_range(0, 6) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
        send_item(make_item(pick_word(), count, i == 0, 1'b0, len));
      end
    end
  endtask

  // stray item with no start marker
  task automatic send_stray();
    send_item(make_item($urandom, 3'($urandom_range(0, 7)), 1'b0,
                        1'($urandom_range(0, 1)), $urandom));
  endtask

  task automatic run_random(int target);
    int pick;
    while (items_counted < target) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) send_stray();
      else if (pick == 1) send_message(1'b0);
      else send_message(1'b1);
    end
    // leave no message open across a seed change
    if (sb.msg_open) send_message(1'b1);
  endtask

  // corner cases under the reset seed
  task automatic run_directed();
    // stray item before any message is dropped
    send_item(make_item(32'hffff_ffff, 3'd4, 1'b0, 1'b0, 32'hffff_ffff));
    // empty message, then one-item messages over every byte count
    send_item(make_item(32'hffff_ffff, 3'd0, 1'b1, 1'b1, 32'h0));
    send_item(make_item(32'hffff_ffff, 3'd1, 1'b1, 1'b1, 32'h1));
    send_item(make_item(32'ha5a5_a5a5, 3'd2, 1'b1, 1'b1, 32'h2));
    send_item(make_item(32'hffff_ffff, 3'd3, 1'b1, 1'b1, 32'hffff_ffff));
    send_item(make_item(32'hffff_ffff, 3'd4, 1'b1, 1'b1, 32'h4));
    send_item(make_item(32'h0000_0000, 3'd4, 1'b1, 1'b1, 32'h0));
    send_item(make_item($urandom, 3'd5, 1'b1, 1'b1, 32'h5));
    send_item(make_item($urandom, 3'd6, 1'b1, 1'b1, 32'h6));
    send_item(make_item($urandom, 3'd7, 1'b1, 1'b1, 32'h7));
    // short count on an inner word, then a three byte tail
    send_item(make_item(32'h0000_0000, 3'd4, 1'b1, 1'b0, 32'hffff_ffff));
    send_item(make_item(32'hffff_ffff, 3'd1, 1'b0, 1'b0, 32'h0));
    send_item(make_item(32'hffff_ffff, 3'd0, 1'b0, 1'b0, 32'h0));
    send_item(make_item(32'h1234_5678, 3'd3, 1'b0, 1'b1, 32'h0));
    // stray last item after the message closed
    send_item(make_item(32'hdead_beef, 3'd2, 1'b0, 1'b1, 32'h3));
    // message abandoned by a new start
    send_item(make_item(32'h1234_5678, 3'd4, 1'b1, 1'b0, 32'h8));
    send_item(make_item(32'h8765_4321, 3'd4, 1'b0, 1'b0, 32'h8));
    send_item(make_item(32'hcafe_f00d, 3'd4, 1'b1, 1'b0, 32'h4));
    send_item(make_item(32'h0000_0000, 3'd0, 1'b0, 1'b1, 32'h4));
    // two full words and a full last word
    send_item(make_item(32'h0102_0304, 3'd4, 1'b1, 1'b0, 32'hc));
    send_item(make_item(32'hffff_ffff, 3'd4, 1'b0, 1'b0, 32'hc));
    send_item(make_item(32'h8000_0001, 3'd4, 1'b0, 1'b1, 32'hc));
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [31:0] seeds[7];
    int          p;
    seeds = '{32'hffff_ffff, 32'h0000_0000, $urandom, 32'h8000_0000,
              $urandom, 32'h0000_0001, $urandom};
    sb             = new();
    items_counted  = 0;
    burst_left     = 0;
    rst            <= 1'b1;
    cfg_valid      <= 1'b0;
    seed_value     <= '0;
    in_valid       <= 1'b0;
    data_word      <= '0;
    valid_bytes    <= '0;
    first_item     <= 1'b0;
    last_item      <= 1'b0;
    message_length <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    for (p = 0; p < 7; p++) begin
      write_seed(seeds[p]);
      run_random(items_counted + PHASE_ITEMS);
    end
    in_valid <= 1'b0;

    // drain, then give the block time to show any extra result
    while (sb.expected_hashes.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
